[rtl/rtc_alarm_periodic_timer_top_macros.svh]
// Assertion macros for the RTC alarm / periodic timer block.
`ifndef RTC_ALARM_PERIODIC_TIMER_TOP_MACROS_SVH
`define RTC_ALARM_PERIODIC_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RTCAPT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RTCAPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTCAPT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RTCAPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/rtcapt_pkg.sv]
// Types and constants shared by the RTC alarm / periodic timer modules.
package rtcapt_pkg;

  typedef enum logic [1:0] {
    KIND_RTC_TICK   = 2'd0,
    KIND_TIMER_TICK = 2'd1,
    KIND_REG_READ   = 2'd2,
    KIND_REG_WRITE  = 2'd3
  } kind_t;

  localparam logic [2:0] REG_COUNT_HI = 3'd0;
  localparam logic [2:0] REG_COUNT_LO = 3'd1;
  localparam logic [2:0] REG_ALARM_HI = 3'd2;
  localparam logic [2:0] REG_ALARM_LO = 3'd3;
  localparam logic [2:0] REG_CONTROL  = 3'd4;
  localparam logic [2:0] REG_PERIODIC = 3'd5;

  localparam logic [31:0] CTL_RESERVED  = 32'hFFFF_FF00;
  localparam logic [31:0] CTL_UNMODELED = 32'h0000_00E7;
  localparam int          CTL_CLEAR_BIT    = 3;
  localparam int          CTL_PERIODIC_BIT = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        rollover_irq;
    logic        alarm_irq;
    logic        periodic_irq;
  } result_t;

endpackage

[rtl/rtc_alarm_periodic_timer_top.sv]
// RTC alarm / periodic timer: input register, update logic, result register.
// Flow: an accepted item is held in the input register; its result is loaded
//   into the output register when stage 1 advances.
// Throughput: one item per cycle while the output is not stalled; the state update path is combinational.
// Reset: synchronous, active low; clears all timer state and the valid flags of both stages.
`include "rtc_alarm_periodic_timer_top_macros.svh"

module rtc_alarm_periodic_timer_top #(
  parameter int COUNTER_BITS = 40,
  parameter int PERIOD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_access_error,
  output logic        out_rollover_irq,
  output logic        out_alarm_irq,
  output logic        out_periodic_irq
);
  import rtcapt_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    advance;
  logic    in_fire;

  // stage 1 moves on whenever the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind       <= in_kind;
      s1_item_r.reg_index  <= in_reg_index;
      s1_item_r.write_data <= in_write_data;
    end
  end

  rtcapt_core #(
    .CNT_BITS (COUNTER_BITS),
    .PER_BITS (PERIOD_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_res_r.read_data;
  assign out_access_error = out_res_r.access_error;
  assign out_rollover_irq = out_res_r.rollover_irq;
  assign out_alarm_irq    = out_res_r.alarm_irq;
  assign out_periodic_irq = out_res_r.periodic_irq;

  `RTCAPT_ASSERT_IMPL(a_err_only_access, clk, rst_n, advance && res.access_error, (s1_item_r.kind == KIND_REG_READ) || (s1_item_r.kind == KIND_REG_WRITE), "access error on a tick item")
  `RTCAPT_ASSERT_IMPL(a_rd_zero_nonread, clk, rst_n, advance && (s1_item_r.kind != KIND_REG_READ), res.read_data == '0, "read data nonzero on non-read item")
  `RTCAPT_ASSERT_IMPL(a_per_irq_timer, clk, rst_n, advance && res.periodic_irq, s1_item_r.kind == KIND_TIMER_TICK, "periodic irq without timer tick")
  `RTCAPT_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r, "result register not loaded")

endmodule

[rtl/rtcapt_core.sv]
// RTC state registers and the single-pass item update / result logic.
module rtcapt_core #(
  parameter int CNT_BITS = 40,
  parameter int PER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  rtcapt_pkg::item_t   item,
  output rtcapt_pkg::result_t res
);
  import rtcapt_pkg::*;

  localparam int HI_BITS = CNT_BITS - 32;

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] alarm_r, alarm_nxt;
  logic                armed_r, armed_nxt;
  logic                alarm_done_r, alarm_done_nxt;
  logic                roll_done_r, roll_done_nxt;
  logic                clear_hold_r, clear_hold_nxt;
  logic                per_on_r, per_on_nxt;
  logic [PER_BITS-1:0] reload_r, reload_nxt;
  logic [PER_BITS-1:0] left_r, left_nxt;
  logic [7:0]          ctl_r, ctl_nxt;

  logic [PER_BITS-1:0] per_cnt;
  logic                clr_bit, per_bit;
  logic                ctl_bad;
  logic [31:0]         wd;

  assign wd      = item.write_data;
  assign clr_bit = wd[CTL_CLEAR_BIT];
  assign per_bit = wd[CTL_PERIODIC_BIT];
  assign ctl_bad = ((wd & CTL_RESERVED) != '0) || ((wd & CTL_UNMODELED) != '0);
  assign per_cnt = (per_on_r && (left_r < reload_r)) ? left_r : reload_r;

  always_comb begin
    cnt_nxt        = cnt_r;
    alarm_nxt      = alarm_r;
    armed_nxt      = armed_r;
    alarm_done_nxt = alarm_done_r;
    roll_done_nxt  = roll_done_r;
    clear_hold_nxt = clear_hold_r;
    per_on_nxt     = per_on_r;
    reload_nxt     = reload_r;
    left_nxt       = left_r;
    ctl_nxt        = ctl_r;
    res            = '0;

    case (kind_t'(item.kind))
      KIND_RTC_TICK: begin
        if (!clear_hold_r) cnt_nxt = cnt_r + 1'b1;
      end
      KIND_TIMER_TICK: begin
        if (per_on_r) begin
          if (left_r == '0) begin
            res.periodic_irq = 1'b1;
            left_nxt         = reload_r;
          end else begin
            left_nxt = left_r - 1'b1;
          end
        end
      end
      KIND_REG_READ: begin
        case (item.reg_index)
          REG_COUNT_HI: res.read_data = 32'(cnt_r[CNT_BITS-1:32]);
          REG_COUNT_LO: res.read_data = cnt_r[31:0];
          REG_ALARM_HI: res.read_data = 32'(alarm_r[CNT_BITS-1:32]);
          REG_ALARM_LO: res.read_data = alarm_r[31:0];
          REG_CONTROL:  res.read_data = 32'(ctl_r);
          REG_PERIODIC: res.read_data = {16'(per_cnt), 16'(reload_r)};
          default:      res.access_error = 1'b1;
        endcase
      end
      KIND_REG_WRITE: begin
        case (item.reg_index)
          REG_ALARM_HI: begin
            alarm_nxt[CNT_BITS-1:32] = wd[HI_BITS-1:0];
            armed_nxt                = 1'b1;
            alarm_done_nxt           = 1'b0;
          end
          REG_ALARM_LO: begin
            alarm_nxt[31:0] = wd;
            armed_nxt       = 1'b1;
            alarm_done_nxt  = 1'b0;
          end
          REG_CONTROL: begin
            if (ctl_bad) begin
              res.access_error = 1'b1;
            end else begin
              if (clr_bit) cnt_nxt = '0;
              // releasing the hold restarts the count and re-enables both irqs
              if (clear_hold_r && !clr_bit) begin
                cnt_nxt        = '0;
                alarm_done_nxt = 1'b0;
                roll_done_nxt  = 1'b0;
              end
              clear_hold_nxt = clr_bit;
              if (per_bit && !per_on_r) left_nxt = reload_r;
              per_on_nxt = per_bit;
              ctl_nxt    = wd[7:0];
            end
          end
          REG_PERIODIC: reload_nxt = wd[PER_BITS-1:0];
          default:      res.access_error = 1'b1;
        endcase
      end
      default: ;
    endcase

    // interrupt checks run on the post-update state
    if (!clear_hold_nxt) begin
      if (armed_nxt && !alarm_done_nxt && (roll_done_nxt || (cnt_nxt >= alarm_nxt))) begin
        alarm_done_nxt = 1'b1;
        res.alarm_irq  = 1'b1;
      end
      if (!roll_done_nxt && (&cnt_nxt)) begin
        roll_done_nxt    = 1'b1;
        res.rollover_irq = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      alarm_r      <= '0;
      armed_r      <= 1'b0;
      alarm_done_r <= 1'b0;
      roll_done_r  <= 1'b0;
      clear_hold_r <= 1'b0;
      per_on_r     <= 1'b0;
      reload_r     <= '0;
      left_r       <= '0;
      ctl_r        <= '0;
    end else if (fire) begin
      cnt_r        <= cnt_nxt;
      alarm_r      <= alarm_nxt;
      armed_r      <= armed_nxt;
      alarm_done_r <= alarm_done_nxt;
      roll_done_r  <= roll_done_nxt;
      clear_hold_r <= clear_hold_nxt;
      per_on_r     <= per_on_nxt;
      reload_r     <= reload_nxt;
      left_r       <= left_nxt;
      ctl_r        <= ctl_nxt;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the RTC alarm / periodic timer block.
`timescale 1ns / 100ps

module tb;
  import rtcapt_pkg::*;

  localparam int CNT_BITS       = 40;
  localparam int PER_BITS       = 16;
  localparam int RANDOM_ITEMS   = 1820;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam logic [CNT_BITS-1:0] CNT_ALL_ONES = {CNT_BITS{1'b1}};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_RTC_TICK;
  logic [2:0]  in_reg_index = 3'd0;
  logic [31:0] in_write_data = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_access_error;
  logic        out_rollover_irq;
  logic        out_alarm_irq;
  logic        out_periodic_irq;

  rtc_alarm_periodic_timer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_access_error (out_access_error),
    .out_rollover_irq (out_rollover_irq),
    .out_alarm_irq    (out_alarm_irq),
    .out_periodic_irq (out_periodic_irq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer state as the predictor sees it
  logic [CNT_BITS-1:0] rtc_cnt = '0;
  logic [CNT_BITS-1:0] alm_val = '0;
  logic                alm_armed = 1'b0;
  logic                alm_fired = 1'b0;
  logic                roll_fired = 1'b0;
  logic                hold_clr = 1'b0;
  logic                per_en = 1'b0;
  logic [PER_BITS-1:0] per_reload = '0;
  logic [PER_BITS-1:0] per_left = '0;
  logic [7:0]          ctl_word = '0;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   next_item;
  result_t want;

  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int alarm_hits = 0;
  int periodic_hits = 0;
  int error_hits = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;
  int idle_cycles = 0;

  function automatic result_t timer_step(item_t it);
    result_t r;
    logic [PER_BITS-1:0] shown;
    logic clr;
    logic pe;
    r = '0;
    case (it.kind)
      KIND_RTC_TICK: begin
        if (!hold_clr) rtc_cnt = rtc_cnt + 1'b1;
      end
      KIND_TIMER_TICK: begin
        if (per_en) begin
          if (per_left == '0) begin
            r.periodic_irq = 1'b1;
            per_left = per_reload;
          end else begin
            per_left = per_left - 1'b1;
          end
        end
      end
      KIND_REG_READ: begin
        case (it.reg_index)
          REG_COUNT_HI: r.read_data = 32'(rtc_cnt >> 32);
          REG_COUNT_LO: r.read_data = rtc_cnt[31:0];
          REG_ALARM_HI: r.read_data = 32'(alm_val >> 32);
          REG_ALARM_LO: r.read_data = alm_val[31:0];
          REG_CONTROL:  r.read_data = {24'd0, ctl_word};
          REG_PERIODIC: begin
            shown = (per_en && per_left < per_reload) ? per_left : per_reload;
            r.read_data = {shown, per_reload};
          end
          default: r.access_error = 1'b1;
        endcase
      end
      default: begin
        case (it.reg_index)
          REG_ALARM_HI: begin
            alm_val = CNT_BITS'({it.write_data, alm_val[31:0]});
            alm_armed = 1'b1;
            alm_fired = 1'b0;
          end
          REG_ALARM_LO: begin
            alm_val = {alm_val[CNT_BITS-1:32], it.write_data};
            alm_armed = 1'b1;
            alm_fired = 1'b0;
          end
          REG_CONTROL: begin
            if ((it.write_data & CTL_RESERVED) != 0 || (it.write_data & CTL_UNMODELED) != 0) begin
              r.access_error = 1'b1;
            end else begin
              clr = it.write_data[CTL_CLEAR_BIT];
              pe = it.write_data[CTL_PERIODIC_BIT];
              if (clr) rtc_cnt = '0;
              // releasing the hold restarts the counter and re-enables both events
              if (hold_clr && !clr) begin
                rtc_cnt = '0;
                alm_fired = 1'b0;
                roll_fired = 1'b0;
              end
              hold_clr = clr;
              if (pe && !per_en) per_left = per_reload;
              per_en = pe;
              ctl_word = it.write_data[7:0];
            end
          end
          REG_PERIODIC: per_reload = it.write_data[PER_BITS-1:0];
          default: r.access_error = 1'b1;
        endcase
      end
    endcase
    if (!hold_clr) begin
      // after a rollover every armed alarm counts as met
      if (alm_armed && !alm_fired && (roll_fired || rtc_cnt >= alm_val)) begin
        alm_fired = 1'b1;
        r.alarm_irq = 1'b1;
      end
      if (!roll_fired && rtc_cnt == CNT_ALL_ONES) begin
        roll_fired = 1'b1;
        r.rollover_irq = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void add_item(kind_t k, logic [2:0] idx, logic [31:0] d);
    item_t it;
    it.kind = k;
    it.reg_index = idx;
    it.write_data = d;
    pending_items.push_back(it);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  function automatic void add_random_item();
    int sel;
    logic [31:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      add_item(KIND_RTC_TICK, 3'($urandom), $urandom);
    end else if (sel < 55) begin
      add_item(KIND_TIMER_TICK, 3'($urandom), $urandom);
    end else if (sel < 72) begin
      add_item(KIND_REG_READ, 3'($urandom_range(0, 7)), $urandom);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        d = ($urandom_range(0, 9) != 0) ? 32'($urandom_range(0, 80)) : $urandom;
        add_item(KIND_REG_WRITE, REG_ALARM_LO, d);
      end else if (sel < 40) begin
        d = ($urandom_range(0, 6) != 0) ? 32'd0 : $urandom;
        add_item(KIND_REG_WRITE, REG_ALARM_HI, d);
      end else if (sel < 70) begin
        case ($urandom_range(0, 9))
          0: d = $urandom;
          1: d = 32'd1 << $urandom_range(0, 31);
          default: begin
            d = '0;
            d[CTL_CLEAR_BIT] = 1'($urandom);
            d[CTL_PERIODIC_BIT] = 1'($urandom);
          end
        endcase
        add_item(KIND_REG_WRITE, REG_CONTROL, d);
      end else if (sel < 85) begin
        d = ($urandom_range(0, 7) != 0) ? 32'($urandom_range(0, 6)) : $urandom;
        add_item(KIND_REG_WRITE, REG_PERIODIC, d);
      end else begin
        case ($urandom_range(0, 3))
          0: add_item(KIND_REG_WRITE, REG_COUNT_HI, $urandom);
          1: add_item(KIND_REG_WRITE, REG_COUNT_LO, $urandom);
          2: add_item(KIND_REG_WRITE, REG_SPARE_A, $urandom);
          default: add_item(KIND_REG_WRITE, REG_SPARE_B, $urandom);
        endcase
      end
    end
  endfunction

  // Driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(timer_step({in_kind, in_reg_index, in_write_data}));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          in_kind <= next_item.kind;
          in_reg_index <= next_item.reg_index;
          in_write_data <= next_item.write_data;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item arrived with nothing expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("access_error", want.access_error, out_access_error);
          check_field("rollover_irq", want.rollover_irq, out_rollover_irq);
          check_field("alarm_irq", want.alarm_irq, out_alarm_irq);
          check_field("periodic_irq", want.periodic_irq, out_periodic_irq);
          alarm_hits += want.alarm_irq;
          periodic_hits += want.periodic_irq;
          error_hits += want.access_error;
        end
      end
      stall_cyc++;
      if (stall_cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ((stall_cyc % 5) < 3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // register map sweep, including the two unused indexes
    for (int i = 0; i < 8; i++) add_item(KIND_REG_READ, 3'(i), 32'd0);
    add_item(KIND_REG_WRITE, REG_COUNT_HI, 32'hFFFF_FFFF);
    add_item(KIND_REG_WRITE, REG_COUNT_LO, 32'd0);
    add_item(KIND_REG_WRITE, REG_SPARE_A, 32'h1234_5678);
    add_item(KIND_REG_WRITE, REG_SPARE_B, 32'hFFFF_FFFF);
    // control words with reserved or unmodeled bits are refused
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'h0000_0100);
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'hFFFF_FFFF);
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'h0000_0001);
    add_item(KIND_REG_WRITE, REG_PERIODIC, 32'hFFFF_FFFF);
    add_item(KIND_REG_WRITE, REG_PERIODIC, 32'd2);
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'h0000_0010);
    repeat (3) add_item(KIND_TIMER_TICK, 3'd0, 32'd0);
    add_item(KIND_REG_READ, REG_PERIODIC, 32'd0);
    // alarm armed at a value already met fires in the same item
    add_item(KIND_REG_WRITE, REG_ALARM_HI, 32'hFFFF_FFFF);
    add_item(KIND_REG_WRITE, REG_ALARM_HI, 32'd0);
    add_item(KIND_REG_WRITE, REG_ALARM_LO, 32'd3);
    repeat (3) add_item(KIND_RTC_TICK, 3'd0, 32'd0);
    // hold the counter in clear, tick, then release
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'h0000_0018);
    add_item(KIND_RTC_TICK, 3'd0, 32'd0);
    add_item(KIND_REG_WRITE, REG_CONTROL, 32'h0000_0000);
    add_item(KIND_TIMER_TICK, 3'd0, 32'd0);
    repeat (RANDOM_ITEMS) add_random_item();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d items and %0d result items under random bursts and stalls.",
             items_sent, results_seen);
    $display("Seen: %0d access errors, %0d alarm and %0d periodic interrupts.",
             error_hits, alarm_hits, periodic_hits);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
